/* rtl/core/fbfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfa_pkg
// Shared constants, widths and control types of the block allocator.
// ----------------------------------------------------------------------------
package fbfa_pkg;

   // arena and block table dimensions
   localparam int ARENA_BYTES  = 65536;
   localparam int MAX_BLOCKS   = 256;
   localparam int HEADER_BYTES = 8;

   // item field widths
   localparam int REQ_W    = 16;
   localparam int ADDR_W   = 16;
   localparam int STATUS_W = 2;
   localparam int MODE_W   = 1;

   // derived widths
   localparam int IDX_W    = $clog2(MAX_BLOCKS);
   localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
   localparam int ARENA_W  = $clog2(ARENA_BYTES + 1);
   localparam int NEED_W   = $clog2((1 << REQ_W) + HEADER_BYTES);
   localparam int SIZE_W   = (ARENA_W > NEED_W) ? ARENA_W : NEED_W;
   localparam int SUM_W    = SIZE_W + 1;
   localparam int ENTRY_W  = SIZE_W + 1;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // fit modes
   localparam logic MODE_FIRST = 1'b0;
   localparam logic MODE_BEST  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture an accepted item
      logic scan;     // walk the block table
      logic commit;   // update state and load the result
   } fbfa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } fbfa_sts_type;

endpackage : fbfa_pkg
`default_nettype wire

/* rtl/core/first_best_fit_block_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_best_fit_block_allocator
// Heap block allocator over a byte arena with first fit or best fit reuse.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): op 0 allocates req_request_size payload bytes,
//   op 1 frees the block whose payload starts at req_release_address.
//   Response channel (rsp_*): one item per request, the payload offset of
//   the allocated block (zero on free or error) and a status code.
//   csr_we/csr_wdata write fit_mode (0 first fit, 1 best fit); write it only
//   while no request is in flight.
// Timing:
//   One request is in flight at a time. A request walks the block table one
//   entry per cycle through the registered RAM read; a first fit or free
//   that hits early ends the walk there. The next request is accepted the
//   cycle after the commit. The response sits in an output register, so a
//   new request is accepted while the previous response still waits; a
//   stalled response holds and blocks only the commit of the following
//   request.
// Reset:
//   Clears the block count, the arena end and fit_mode; table contents are
//   only read below the block count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_best_fit_block_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [fbfa_pkg::MODE_W-1:0]   csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [fbfa_pkg::REQ_W-1:0]    req_request_size,
   input  wire logic [fbfa_pkg::ADDR_W-1:0]   req_release_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [fbfa_pkg::ADDR_W-1:0]   rsp_payload_address,
   output logic      [fbfa_pkg::STATUS_W-1:0] rsp_status
);
   import fbfa_pkg::*;

   fbfa_cmd_type cmd;
   fbfa_sts_type sts;

   // sequencer
   fbfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table and walk
   fbfa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_op              (req_op),
      .req_request_size    (req_request_size),
      .req_release_address (req_release_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload_address (rsp_payload_address),
      .rsp_status          (rsp_status)
   );

endmodule : first_best_fit_block_allocator
`default_nettype wire

/* rtl/core/fbfa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : fbfa_ram
`default_nettype wire

/* rtl/core/fbfa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfa_ctrl
// Sequencer of the allocator: accept an item, walk the table, commit.
// ----------------------------------------------------------------------------
module fbfa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire fbfa_pkg::fbfa_sts_type sts,
   output fbfa_pkg::fbfa_cmd_type     cmd
);
   import fbfa_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // take a new item only between requests
   assign req_stall  = (state_ff != IDLE);
   assign cmd.load   = (state_ff == IDLE) && req_valid;
   assign cmd.scan   = (state_ff == SCAN);
   assign cmd.commit = (state_ff == COMMIT) && sts.out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               state_in = SCAN;
            end
         end
         SCAN: begin
            if (sts.scan_done) begin
               state_in = COMMIT;
            end
         end
         COMMIT: begin
            if (sts.out_free) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : fbfa_ctrl
`default_nettype wire

/* rtl/core/fbfa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfa_datapath
// Block table, table walk with running offsets, fit selection and result
// register of the allocator.
// ----------------------------------------------------------------------------
module fbfa_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire fbfa_pkg::fbfa_cmd_type          cmd,
   output fbfa_pkg::fbfa_sts_type               sts,
   input  wire logic                            csr_we,
   input  wire logic [fbfa_pkg::MODE_W-1:0]     csr_wdata,
   input  wire logic                            req_op,
   input  wire logic [fbfa_pkg::REQ_W-1:0]      req_request_size,
   input  wire logic [fbfa_pkg::ADDR_W-1:0]     req_release_address,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [fbfa_pkg::ADDR_W-1:0]     rsp_payload_address,
   output logic      [fbfa_pkg::STATUS_W-1:0]   rsp_status
);
   import fbfa_pkg::*;

   // configuration
   logic                fit_mode_ff;

   // table bookkeeping
   logic [CNT_W-1:0]    count_ff,   count_in;
   logic [SIZE_W-1:0]   end_ff,     end_in;

   // captured item
   logic                op_ff;
   logic [SIZE_W-1:0]   need_ff;
   logic [ADDR_W-1:0]   rel_ff;

   // walk state
   logic [CNT_W-1:0]    rd_idx_ff,  rd_idx_in;
   logic                pend_ff,    pend_in;
   logic [IDX_W-1:0]    ent_idx_ff;
   logic [SIZE_W-1:0]   addr_ff,    addr_in;
   logic                found_ff,   found_in;
   logic [IDX_W-1:0]    pick_idx_ff, pick_idx_in;
   logic [SIZE_W-1:0]   pick_addr_ff, pick_addr_in;
   logic [SIZE_W-1:0]   pick_size_ff, pick_size_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff,  rsp_addr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // table port
   logic                issue;
   logic [ENTRY_W-1:0]  rd_data;
   logic                ent_free;
   logic [SIZE_W-1:0]   ent_size;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;

   // walk decisions
   logic                hit_alloc;
   logic                hit_free;
   logic                better;
   logic                stop;
   logic                no_room;

   assign ent_free = rd_data[ENTRY_W-1];
   assign ent_size = rd_data[SIZE_W-1:0];

   // read one entry per cycle below the block count
   assign issue = cmd.scan && (rd_idx_ff < count_ff);

   assign hit_alloc = ent_free && (ent_size >= need_ff);
   assign hit_free  = (SUM_W'(addr_ff) + SUM_W'(HEADER_BYTES)) == SUM_W'(rel_ff);
   assign better    = (fit_mode_ff == MODE_FIRST) || !found_ff || (ent_size < pick_size_ff);
   assign stop      = pend_ff && ((op_ff == OP_FREE) ? hit_free
                                  : (hit_alloc && (fit_mode_ff == MODE_FIRST)));

   assign sts.scan_done = cmd.scan && (stop || (!pend_ff && !issue));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign no_room = (count_ff >= CNT_W'(MAX_BLOCKS))
                 || ((SUM_W'(end_ff) + SUM_W'(need_ff)) > SUM_W'(ARENA_BYTES));

   fbfa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // walk: advance read index, accumulate offsets, track the pick
   always_comb begin
      rd_idx_in    = rd_idx_ff;
      pend_in      = 1'b0;
      addr_in      = addr_ff;
      found_in     = found_ff;
      pick_idx_in  = pick_idx_ff;
      pick_addr_in = pick_addr_ff;
      pick_size_in = pick_size_ff;
      if (cmd.load) begin
         rd_idx_in = '0;
         addr_in   = '0;
         found_in  = 1'b0;
      end else if (cmd.scan) begin
         if (issue) begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
         pend_in = issue && !stop;
         if (pend_ff) begin
            addr_in = addr_ff + ent_size;
            if ((op_ff == OP_ALLOC) ? (hit_alloc && better) : hit_free) begin
               found_in     = 1'b1;
               pick_idx_in  = ent_idx_ff;
               pick_addr_in = addr_ff;
               pick_size_in = ent_size;
            end
         end
      end
   end

   // commit: table write, bookkeeping and result
   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = pick_idx_ff;
      wr_data       = {1'b0, pick_size_ff};
      count_in      = count_ff;
      end_in        = end_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = '0;
         if (op_ff == OP_FREE) begin
            if (found_ff) begin
               wr_en         = 1'b1;
               wr_data       = {1'b1, pick_size_ff};
               rsp_status_in = ST_OK;
            end else begin
               rsp_status_in = ST_BAD_FREE;
            end
         end else if (found_ff) begin
            wr_en         = 1'b1;
            rsp_status_in = ST_OK;
            rsp_addr_in   = ADDR_W'(SUM_W'(pick_addr_ff) + SUM_W'(HEADER_BYTES));
         end else if (no_room) begin
            rsp_status_in = ST_NO_SPACE;
         end else begin
            // append a new block at the arena end
            wr_en         = 1'b1;
            wr_addr       = count_ff[IDX_W-1:0];
            wr_data       = {1'b0, need_ff};
            count_in      = count_ff + CNT_W'(1);
            end_in        = end_ff + need_ff;
            rsp_status_in = ST_OK;
            rsp_addr_in   = ADDR_W'(SUM_W'(end_ff) + SUM_W'(HEADER_BYTES));
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= MODE_FIRST;
         count_ff     <= '0;
         end_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            fit_mode_ff <= csr_wdata[0];
         end
         count_ff     <= count_in;
         end_ff       <= end_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         need_ff <= SIZE_W'(req_request_size) + SIZE_W'(HEADER_BYTES);
         rel_ff  <= req_release_address;
      end
      if (issue) begin
         ent_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
      rd_idx_ff     <= rd_idx_in;
      addr_ff       <= addr_in;
      found_ff      <= found_in;
      pick_idx_ff   <= pick_idx_in;
      pick_addr_ff  <= pick_addr_in;
      pick_size_ff  <= pick_size_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

`ifndef SYNTH
   // a commit always leaves a result waiting
   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not load a result");

   // an error or a free never reports an address
   a_err_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_status_ff != ST_OK) || (op_ff == OP_FREE))
       && $rose(rsp_valid_ff)) |-> (rsp_addr_ff == '0))
      else $error("result address not zero on error or free");

   // the arena end never passes the arena size
   a_end_in_arena: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(end_ff) <= SUM_W'(ARENA_BYTES))
      else $error("arena end past arena size");

   // the block count moves only on a commit
   a_count_on_commit: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(count_ff) || $past(reset))
      else $error("block count changed without a commit");
`endif

endmodule : fbfa_datapath
`default_nettype wire

/* verif/tb_first_best_fit_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_best_fit_block_allocator
// Self-checking bench for the first fit / best fit block allocator. A queue
// of pending requests feeds a clocked driver; a clocked monitor predicts the
// response of every accepted request from a local copy of the block table
// and compares each response in order. Directed cases cover empty table,
// double free, bad free, tie-breaks and arena limits; random phases mix
// well-formed alloc/free traffic with noise under several idle patterns,
// and a final pass fills the block table up to the arena end.
// ----------------------------------------------------------------------------
module tb_first_best_fit_block_allocator;
   import fbfa_pkg::*;

   localparam int CLK_HALF        = 5;
   localparam int SETTLE_CYCLES   = 300;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int RANDOM_ITEMS    = 85;

   typedef struct packed {
      logic              op;
      logic [REQ_W-1:0]  size;
      logic [ADDR_W-1:0] rel;
   } alloc_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [STATUS_W-1:0] status;
   } alloc_rsp_type;

   logic                clock               = 1'b0;
   logic                reset               = 1'b1;
   logic                csr_we              = 1'b0;
   logic [MODE_W-1:0]   csr_wdata           = '0;
   logic                req_valid           = 1'b0;
   logic                req_stall;
   logic                req_op              = OP_ALLOC;
   logic [REQ_W-1:0]    req_request_size    = '0;
   logic [ADDR_W-1:0]   req_release_address = '0;
   logic                rsp_valid;
   logic                rsp_stall           = 1'b0;
   logic [ADDR_W-1:0]   rsp_payload_address;
   logic [STATUS_W-1:0] rsp_status;

   // shadow of the block table
   logic              blk_free [MAX_BLOCKS];
   logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
   int unsigned       blk_count      = 0;
   int unsigned       arena_end      = 0;
   logic              fit_mode_model = MODE_FIRST;

   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_rsps[$];
   alloc_req_type drive_item;
   alloc_rsp_type want;
   bit         req_fired      = 1'b0;
   int         error_count    = 0;
   int         send_idle_pct  = 0;
   int         recv_stall_pct = 0;
   bit         hold_off_req   = 1'b0;
   bit         hold_off_done  = 1'b0;
   int         hold_left      = 0;

   first_best_fit_block_allocator uut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_request_size    (req_request_size),
      .req_release_address (req_release_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload_address (rsp_payload_address),
      .rsp_status          (rsp_status)
   );

   always #CLK_HALF clock = ~clock;

   // Advance the shadow table by one request and return its response.
   function automatic alloc_rsp_type allocator_step(input logic op,
                                                    input logic [REQ_W-1:0] size,
                                                    input logic [ADDR_W-1:0] rel);
      alloc_rsp_type res;
      int unsigned need, base, pick_base, pick_size, pick, k;
      bit          found;
      res.addr   = '0;
      res.status = ST_OK;
      base       = 0;
      pick_base  = 0;
      pick_size  = 0;
      pick       = 0;
      found      = 1'b0;
      if (op == OP_ALLOC) begin
         need = size + HEADER_BYTES;
         // scan for a reusable block; first fit keeps the first hit
         for (k = 0; k < blk_count; k++) begin
            if (blk_free[k] && blk_size[k] >= need &&
                (!found || (fit_mode_model == MODE_BEST && blk_size[k] < pick_size))) begin
               found     = 1'b1;
               pick      = k;
               pick_base = base;
               pick_size = blk_size[k];
            end
            base += blk_size[k];
         end
         if (found) begin
            blk_free[pick] = 1'b0;
            res.addr       = ADDR_W'(pick_base + HEADER_BYTES);
         end else if (blk_count >= MAX_BLOCKS || arena_end + need > ARENA_BYTES) begin
            res.status = ST_NO_SPACE;
         end else begin
            // append at the arena end
            blk_free[blk_count] = 1'b0;
            blk_size[blk_count] = SIZE_W'(need);
            blk_count++;
            res.addr  = ADDR_W'(arena_end + HEADER_BYTES);
            arena_end += need;
         end
      end else begin
         for (k = 0; k < blk_count && !found; k++) begin
            if (base + HEADER_BYTES == rel) begin
               blk_free[k] = 1'b1;
               found       = 1'b1;
            end
            base += blk_size[k];
         end
         if (!found) res.status = ST_BAD_FREE;
      end
      return res;
   endfunction

   // Check responses, then predict accepted requests and track config writes.
   always @(posedge clock) begin
      req_fired = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               error_count++;
               $display("%0t: response with none expected, address %0d status %0d",
                        $time, rsp_payload_address, rsp_status);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload_address !== want.addr) begin
                  error_count++;
                  $display("%0t: payload_address mismatch, expected %0d, actual %0d",
                           $time, want.addr, rsp_payload_address);
               end
               if (rsp_status !== want.status) begin
                  error_count++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
            end
         end
         if (csr_we) fit_mode_model = csr_wdata[0];
         if (req_valid && !req_stall) begin
            req_fired = 1'b1;
            expected_rsps.push_back(allocator_step(req_op, req_request_size,
                                                   req_release_address));
         end
      end
   end

   // Present the next pending item once the current one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_item = pending_reqs.pop_front();
            req_valid           <= 1'b1;
            req_op              <= drive_item.op;
            req_request_size    <= drive_item.size;
            req_release_address <= drive_item.rel;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall responses at random, with one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_off_req && !hold_off_done) begin
         rsp_stall     <= 1'b1;
         hold_left     <= HOLD_OFF_CYCLES;
         hold_off_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   task automatic push_alloc(input logic [REQ_W-1:0] size);
      alloc_req_type item;
      item.op   = OP_ALLOC;
      item.size = size;
      item.rel  = ADDR_W'($urandom);
      pending_reqs.push_back(item);
   endtask

   task automatic push_free(input logic [ADDR_W-1:0] rel);
      alloc_req_type item;
      item.op   = OP_FREE;
      item.size = REQ_W'($urandom);
      item.rel  = rel;
      pending_reqs.push_back(item);
   endtask

   // Hold until every request is answered, then let the block settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_fit_mode(input logic mode);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly frees of real blocks and small allocs, some exact fits and noise.
   task automatic queue_random_items(input int n);
      int unsigned roll, pick, idx, base, k;
      logic [REQ_W-1:0] size;
      repeat (n) begin
         while (pending_reqs.size() >= 4) @(negedge clock);
         roll = $urandom_range(0, 99);
         pick = $urandom_range(0, 99);
         idx  = (blk_count == 0) ? 0 : $urandom_range(0, blk_count - 1);
         base = HEADER_BYTES;
         for (k = 0; k < idx; k++) base += blk_size[k];
         if (roll < 55 || blk_count == 0) begin
            if (pick < 70)
               size = REQ_W'($urandom_range(0, 120));
            else if (pick < 90)
               size = REQ_W'($urandom_range(0, 1000));
            else if (pick < 97)
               size = (blk_count != 0) ? REQ_W'(blk_size[idx] - HEADER_BYTES) : '0;
            else
               size = pick[0] ? '1 : REQ_W'(ARENA_BYTES - HEADER_BYTES);
            push_alloc(size);
         end else if (roll < 90) begin
            push_free(ADDR_W'(base));
         end else begin
            push_free(roll[0] ? ADDR_W'($urandom) : ADDR_W'(base + $urandom_range(1, 7)));
         end
      end
   endtask

   initial begin : stimulus
      int unsigned free_blocks, fill_blocks, k;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, first fit
      set_fit_mode(MODE_FIRST);
      push_free(16'd8);          // empty table
      push_alloc(16'd0);         // zero size takes a header-only block
      push_alloc(16'd100);
      push_alloc(16'd40);
      push_alloc(16'd100);
      push_free(16'd8);
      push_free(16'd8);          // already free, still ok
      push_free(16'd16);
      push_free(16'd172);
      push_alloc(16'd100);       // first free block large enough
      push_alloc(16'd0);
      push_free(16'd9);
      push_free(16'hFFFF);
      push_alloc(REQ_W'(ARENA_BYTES - HEADER_BYTES));
      push_alloc(16'hFFFF);
      push_free(16'd0);
      push_free(16'd16);
      push_free(16'd124);

      // directed, best fit with a tie between two equal blocks
      set_fit_mode(MODE_BEST);
      push_alloc(16'd40);
      push_alloc(16'd100);
      push_alloc(16'd100);
      push_alloc(16'd0);

      // random phases under different idle patterns
      set_fit_mode(MODE_BEST);
      queue_random_items(RANDOM_ITEMS);

      set_fit_mode(MODE_FIRST);
      send_idle_pct = 67;
      queue_random_items(RANDOM_ITEMS);

      set_fit_mode(MODE_BEST);
      send_idle_pct  = 0;
      recv_stall_pct = 67;
      hold_off_req   = 1'b1;
      queue_random_items(RANDOM_ITEMS);

      set_fit_mode(MODE_FIRST);
      send_idle_pct  = 25;
      recv_stall_pct = 25;
      queue_random_items(RANDOM_ITEMS);

      // take every free block, then fill the table so the last block ends
      // exactly at the arena end and its payload offset wraps
      set_fit_mode(MODE_BEST);
      free_blocks = 0;
      for (k = 0; k < blk_count; k++) if (blk_free[k]) free_blocks++;
      repeat (free_blocks) push_alloc('0);
      if (blk_count < MAX_BLOCKS - 1 &&
          arena_end + HEADER_BYTES * (MAX_BLOCKS - 1 - blk_count) <=
          ARENA_BYTES - HEADER_BYTES) begin
         fill_blocks = MAX_BLOCKS - 1 - blk_count;
         repeat (fill_blocks - 1) push_alloc('0);
         push_alloc(REQ_W'(ARENA_BYTES - 2 * HEADER_BYTES - arena_end -
                           HEADER_BYTES * (fill_blocks - 1)));
         push_alloc('0);
      end else begin
         repeat (MAX_BLOCKS - blk_count) push_alloc('0);
      end
      push_alloc('0);            // table full
      push_free('0);
      push_alloc(REQ_W'(ARENA_BYTES - HEADER_BYTES));

      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
